// ===== rtl/core/pt_comp_pkg.sv =====
// Shared types, constants and helpers for the pressure/temperature compensation pipeline.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package pt_comp_pkg;

   // Field widths
   localparam int RAW_W   = 24;
   localparam int COEF_W  = 16;
   localparam int PRESS_W = 27;
   localparam int TEMPO_W = 19;
   localparam int TEMP_W  = 20;   // internal temperature, one bit of margin
   localparam int OFF_W   = 40;
   localparam int SENS_W  = 39;
   localparam int T2_W    = 17;
   localparam int IDX_W   = 3;

   // Temperature thresholds in 0.01 C
   localparam logic signed [63:0] TEMP_REF = 64'sd2000;
   localparam logic signed [63:0] TEMP_LOW = -64'sd1500;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_C1        = 3'd0;
   localparam logic [IDX_W-1:0] REG_C2        = 3'd1;
   localparam logic [IDX_W-1:0] REG_C3        = 3'd2;
   localparam logic [IDX_W-1:0] REG_C4        = 3'd3;
   localparam logic [IDX_W-1:0] REG_C5        = 3'd4;
   localparam logic [IDX_W-1:0] REG_C6        = 3'd5;
   localparam logic [IDX_W-1:0] REG_CAL_VALID = 3'd6;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_CAL   = 2'd1,
      STATUS_ZERO_RAW = 2'd2
   } status_type;

   typedef struct packed {
      logic [COEF_W-1:0] c1;
      logic [COEF_W-1:0] c2;
      logic [COEF_W-1:0] c3;
      logic [COEF_W-1:0] c4;
      logic [COEF_W-1:0] c5;
      logic [COEF_W-1:0] c6;
      logic              cal_valid;
   } cfg_type;

   // First-order results
   typedef struct packed {
      status_type               status;
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp1;
      logic signed [OFF_W-1:0]  off1;
      logic signed [SENS_W-1:0] sens1;
      logic [T2_W-1:0]          t2;
   } first_type;

   // Second-order corrected values
   typedef struct packed {
      status_type               status;
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
   } second_type;

   // Signed divide by 2^shift, truncating toward zero
   function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] value,
                                                     input int unsigned shift);
      logic signed [63:0] bias;
      bias = value[63] ? $signed((64'd1 << shift) - 64'd1) : 64'sd0;
      return (value + bias) >>> shift;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pt_comp_csr.sv =====
// Calibration coefficient registers with a valid/ready write port.
// Depends on pt_comp_pkg.
`default_nettype none

module pt_comp_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pt_comp_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [pt_comp_pkg::COEF_W-1:0] csr_wdata,
   output pt_comp_pkg::cfg_type               cfg
);

   pt_comp_pkg::cfg_type cfg_ff, cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pt_comp_pkg::REG_C1:        cfg_in.c1 = csr_wdata;
            pt_comp_pkg::REG_C2:        cfg_in.c2 = csr_wdata;
            pt_comp_pkg::REG_C3:        cfg_in.c3 = csr_wdata;
            pt_comp_pkg::REG_C4:        cfg_in.c4 = csr_wdata;
            pt_comp_pkg::REG_C5:        cfg_in.c5 = csr_wdata;
            pt_comp_pkg::REG_C6:        cfg_in.c6 = csr_wdata;
            pt_comp_pkg::REG_CAL_VALID: cfg_in.cal_valid = csr_wdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pt_comp_first.sv =====
// First-order compensation: dT, products with the coefficients, TEMP, OFF, SENS and T2.
// Three register stages. Depends on pt_comp_pkg.
`default_nettype none

module pt_comp_first (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [pt_comp_pkg::RAW_W-1:0] d1,
   input  wire logic [pt_comp_pkg::RAW_W-1:0] d2,
   input  wire pt_comp_pkg::cfg_type         cfg,
   output logic                              out_valid,
   output pt_comp_pkg::first_type            out_data
);

   // Stage A: dT and status
   logic                     va_ff, va_in;
   pt_comp_pkg::status_type  sta_ff, sta_in;
   logic [pt_comp_pkg::RAW_W-1:0] d1a_ff, d1a_in;
   logic signed [24:0]       dt_ff, dt_in;

   assign va_in  = in_valid;
   assign d1a_in = d1;
   assign dt_in  = $signed({1'b0, d2}) - $signed({1'b0, cfg.c5, 8'd0});

   always_comb begin
      if (!cfg.cal_valid) begin
         sta_in = pt_comp_pkg::STATUS_NO_CAL;
      end else if (d1 == '0 || d2 == '0) begin
         sta_in = pt_comp_pkg::STATUS_ZERO_RAW;
      end else begin
         sta_in = pt_comp_pkg::STATUS_OK;
      end
   end

   // Stage B: coefficient products and dT squared
   logic                     vb_ff, vb_in;
   pt_comp_pkg::status_type  stb_ff, stb_in;
   logic [pt_comp_pkg::RAW_W-1:0] d1b_ff, d1b_in;
   logic signed [41:0]       p6_ff, p6_in, p4_ff, p4_in, p3_ff, p3_in;
   logic signed [49:0]       sq_ff, sq_in;

   assign vb_in  = va_ff;
   assign stb_in = sta_ff;
   assign d1b_in = d1a_ff;
   assign p6_in  = dt_ff * $signed({1'b0, cfg.c6});
   assign p4_in  = dt_ff * $signed({1'b0, cfg.c4});
   assign p3_in  = dt_ff * $signed({1'b0, cfg.c3});
   assign sq_in  = dt_ff * dt_ff;

   // Stage C: scale and add the first-order terms
   logic                     vc_ff, vc_in;
   pt_comp_pkg::first_type   oc_ff, oc_in;
   logic [51:0]              sq3;

   assign sq3 = ({2'd0, sq_ff} << 1) + {2'd0, sq_ff};

   assign vc_in = vb_ff;
   always_comb begin
      oc_in.status = stb_ff;
      oc_in.d1     = d1b_ff;
      oc_in.temp1  = pt_comp_pkg::TEMP_W'(pt_comp_pkg::TEMP_REF
                     + pt_comp_pkg::trunc_shift(64'(p6_ff), 23));
      oc_in.off1   = pt_comp_pkg::OFF_W'($signed({32'd0, cfg.c2, 16'd0})
                     + pt_comp_pkg::trunc_shift(64'(p4_ff), 7));
      oc_in.sens1  = pt_comp_pkg::SENS_W'($signed({33'd0, cfg.c1, 15'd0})
                     + pt_comp_pkg::trunc_shift(64'(p3_ff), 8));
      oc_in.t2     = sq3[49:33];
   end

   // Valid bits reset, payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      sta_ff <= sta_in;
      d1a_ff <= d1a_in;
      dt_ff  <= dt_in;
      stb_ff <= stb_in;
      d1b_ff <= d1b_in;
      p6_ff  <= p6_in;
      p4_ff  <= p4_in;
      p3_ff  <= p3_in;
      sq_ff  <= sq_in;
      oc_ff  <= oc_in;
   end

   assign out_valid = vc_ff;
   assign out_data  = oc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pt_comp_second.sv =====
// Second-order low-temperature correction of TEMP, OFF and SENS.
// Three register stages. Depends on pt_comp_pkg.
`default_nettype none

module pt_comp_second (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire pt_comp_pkg::first_type in_data,
   output logic                        out_valid,
   output pt_comp_pkg::second_type     out_data
);

   // Stage D: threshold checks and squares of the temperature deltas
   logic signed [63:0] temp_ext, dd64, dl64;
   logic signed [20:0] dd, dl;
   logic signed [41:0] ddsq_full, dlsq_full;
   logic               low, very_low;

   logic                           vd_ff, vd_in;
   pt_comp_pkg::status_type        std_ff, std_in;
   logic [pt_comp_pkg::RAW_W-1:0]  d1d_ff, d1d_in;
   logic signed [pt_comp_pkg::TEMP_W-1:0] tempd_ff, tempd_in;
   logic signed [pt_comp_pkg::OFF_W-1:0]  off1d_ff, off1d_in;
   logic signed [pt_comp_pkg::SENS_W-1:0] sens1d_ff, sens1d_in;
   logic [35:0]                    ddsq_ff, ddsq_in, dlsq_ff, dlsq_in;

   assign temp_ext  = 64'(in_data.temp1);
   assign dd64      = temp_ext - pt_comp_pkg::TEMP_REF;
   assign dl64      = temp_ext - pt_comp_pkg::TEMP_LOW;
   assign dd        = dd64[20:0];
   assign dl        = dl64[20:0];
   assign low       = temp_ext < pt_comp_pkg::TEMP_REF;
   assign very_low  = temp_ext < pt_comp_pkg::TEMP_LOW;
   assign ddsq_full = dd * dd;
   assign dlsq_full = dl * dl;

   assign vd_in     = in_valid;
   assign std_in    = in_data.status;
   assign d1d_in    = in_data.d1;
   // T2 only applies below the reference temperature
   assign tempd_in  = low ? (in_data.temp1 - $signed({3'd0, in_data.t2})) : in_data.temp1;
   assign off1d_in  = in_data.off1;
   assign sens1d_in = in_data.sens1;
   assign ddsq_in   = low      ? ddsq_full[35:0] : '0;
   assign dlsq_in   = very_low ? dlsq_full[35:0] : '0;

   // Stage E: OFF2 and SENS2
   logic                           ve_ff, ve_in;
   pt_comp_pkg::status_type        ste_ff, ste_in;
   logic [pt_comp_pkg::RAW_W-1:0]  d1e_ff, d1e_in;
   logic signed [pt_comp_pkg::TEMP_W-1:0] tempe_ff, tempe_in;
   logic signed [pt_comp_pkg::OFF_W-1:0]  off1e_ff, off1e_in;
   logic signed [pt_comp_pkg::SENS_W-1:0] sens1e_ff, sens1e_in;
   logic [38:0]                    off2_ff, off2_in;
   logic [37:0]                    sens2_ff, sens2_in;

   assign ve_in     = vd_ff;
   assign ste_in    = std_ff;
   assign d1e_in    = d1d_ff;
   assign tempe_in  = tempd_ff;
   assign off1e_in  = off1d_ff;
   assign sens1e_in = sens1d_ff;
   assign off2_in   = 39'((40'(ddsq_ff) * 40'd3) >> 1) + 39'(40'(dlsq_ff) * 40'd7);
   assign sens2_in  = 38'((40'(ddsq_ff) * 40'd5) >> 3) + 38'(40'(dlsq_ff) * 40'd4);

   // Stage F: subtract the corrections
   logic                    vf_ff, vf_in;
   pt_comp_pkg::second_type of_ff, of_in;

   assign vf_in = ve_ff;
   always_comb begin
      of_in.status = ste_ff;
      of_in.d1     = d1e_ff;
      of_in.temp   = tempe_ff;
      of_in.off    = off1e_ff - $signed({1'b0, off2_ff});
      of_in.sens   = sens1e_ff - $signed({1'b0, sens2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else begin
         vd_ff <= vd_in;
         ve_ff <= ve_in;
         vf_ff <= vf_in;
      end
   end

   always_ff @(posedge clock) begin
      std_ff    <= std_in;
      d1d_ff    <= d1d_in;
      tempd_ff  <= tempd_in;
      off1d_ff  <= off1d_in;
      sens1d_ff <= sens1d_in;
      ddsq_ff   <= ddsq_in;
      dlsq_ff   <= dlsq_in;
      ste_ff    <= ste_in;
      d1e_ff    <= d1e_in;
      tempe_ff  <= tempe_in;
      off1e_ff  <= off1e_in;
      sens1e_ff <= sens1e_in;
      off2_ff   <= off2_in;
      sens2_ff  <= sens2_in;
      of_ff     <= of_in;
   end

   assign out_valid = vf_ff;
   assign out_data  = of_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pt_comp_press.sv =====
// Pressure evaluation: D1*SENS in two partial products, scaling, OFF subtraction,
// and the output register. Five register stages. Depends on pt_comp_pkg.
`default_nettype none

module pt_comp_press (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire pt_comp_pkg::second_type in_data,
   output logic                         rsp_valid,
   output logic [pt_comp_pkg::PRESS_W-1:0] rsp_pressure_dmbar,
   output logic [pt_comp_pkg::TEMPO_W-1:0] rsp_temperature_centi,
   output logic [1:0]                   rsp_status
);

   // Stage G: partial products, SENS split into a low unsigned and a high signed part
   logic                          vg_ff, vg_in;
   pt_comp_pkg::status_type       stg_ff, stg_in;
   logic signed [pt_comp_pkg::TEMP_W-1:0] tempg_ff, tempg_in;
   logic signed [pt_comp_pkg::OFF_W-1:0]  offg_ff, offg_in;
   logic [43:0]                   lo_ff, lo_in;
   logic signed [43:0]            hi_ff, hi_in;

   assign vg_in    = in_valid;
   assign stg_in   = in_data.status;
   assign tempg_in = in_data.temp;
   assign offg_in  = in_data.off;
   assign lo_in    = in_data.d1 * in_data.sens[19:0];
   assign hi_in    = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[38:20]);

   // Stage H: combine into D1*SENS
   logic                          vh_ff, vh_in;
   pt_comp_pkg::status_type       sth_ff, sth_in;
   logic signed [pt_comp_pkg::TEMP_W-1:0] temph_ff, temph_in;
   logic signed [pt_comp_pkg::OFF_W-1:0]  offh_ff, offh_in;
   logic signed [63:0]            prod_ff, prod_in;

   assign vh_in    = vg_ff;
   assign sth_in   = stg_ff;
   assign temph_in = tempg_ff;
   assign offh_in  = offg_ff;
   assign prod_in  = (64'(hi_ff) <<< 20) + $signed({20'd0, lo_ff});

   // Stage I: divide by 2^21
   logic                          vi_ff, vi_in;
   pt_comp_pkg::status_type       sti_ff, sti_in;
   logic signed [pt_comp_pkg::TEMP_W-1:0] tempi_ff, tempi_in;
   logic signed [pt_comp_pkg::OFF_W-1:0]  offi_ff, offi_in;
   logic signed [41:0]            q_ff, q_in;

   assign vi_in    = vh_ff;
   assign sti_in   = sth_ff;
   assign tempi_in = temph_ff;
   assign offi_in  = offh_ff;
   assign q_in     = 42'(pt_comp_pkg::trunc_shift(prod_ff, 21));

   // Stage J: subtract OFF
   logic                          vj_ff, vj_in;
   pt_comp_pkg::status_type       stj_ff, stj_in;
   logic signed [pt_comp_pkg::TEMP_W-1:0] tempj_ff, tempj_in;
   logic signed [42:0]            r_ff, r_in;

   assign vj_in    = vi_ff;
   assign stj_in   = sti_ff;
   assign tempj_in = tempi_ff;
   assign r_in     = 43'(q_ff) - 43'(offi_ff);

   // Stage K: divide by 2^15, wrap to field widths, zero fields on error status
   logic signed [63:0]                 p64;
   logic                               vk_ff, vk_in;
   logic [pt_comp_pkg::PRESS_W-1:0]    press_ff, press_in;
   logic [pt_comp_pkg::TEMPO_W-1:0]    tempk_ff, tempk_in;
   logic [1:0]                         stk_ff, stk_in;

   assign p64      = pt_comp_pkg::trunc_shift(64'(r_ff), 15);
   assign vk_in    = vj_ff;
   assign stk_in   = stj_ff;
   assign press_in = (stj_ff == pt_comp_pkg::STATUS_OK) ? p64[pt_comp_pkg::PRESS_W-1:0] : '0;
   assign tempk_in = (stj_ff == pt_comp_pkg::STATUS_OK) ?
                     tempj_ff[pt_comp_pkg::TEMPO_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
         vi_ff <= 1'b0;
         vj_ff <= 1'b0;
         vk_ff <= 1'b0;
      end else begin
         vg_ff <= vg_in;
         vh_ff <= vh_in;
         vi_ff <= vi_in;
         vj_ff <= vj_in;
         vk_ff <= vk_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_ff   <= stg_in;
      tempg_ff <= tempg_in;
      offg_ff  <= offg_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      sth_ff   <= sth_in;
      temph_ff <= temph_in;
      offh_ff  <= offh_in;
      prod_ff  <= prod_in;
      sti_ff   <= sti_in;
      tempi_ff <= tempi_in;
      offi_ff  <= offi_in;
      q_ff     <= q_in;
      stj_ff   <= stj_in;
      tempj_ff <= tempj_in;
      r_ff     <= r_in;
      press_ff <= press_in;
      tempk_ff <= tempk_in;
      stk_ff   <= stk_in;
   end

   assign rsp_valid             = vk_ff;
   assign rsp_pressure_dmbar    = press_ff;
   assign rsp_temperature_centi = tempk_ff;
   assign rsp_status            = stk_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pressure_temperature_compensation_top.sv =====
// Top level of the pressure/temperature compensation pipeline.
// Instantiates pt_comp_csr, pt_comp_first, pt_comp_second and pt_comp_press; uses pt_comp_pkg.
//
// Usage:
//  - Coefficients C1..C6 and the calibration-valid flag are written on the csr_ port
//    (csr_index 0..6, data in csr_wdata); csr_ready is always high. Write them only
//    while no request is in flight.
//  - A request (req_pressure_raw, req_temperature_raw) is taken on any clock edge with
//    start high; busy is never raised, so one request can enter every cycle.
//  - Each request yields one result on rsp_pressure_dmbar, rsp_temperature_centi and
//    rsp_status, shown for exactly one cycle with rsp_valid high once the request has
//    passed through the 11 register stages (dT, products, first order, squares,
//    corrections, subtraction, partial products of D1*SENS, merge, divide by 2^21,
//    OFF subtraction, output scaling).
//  - Throughput is one result per cycle; results leave in request order.
//  - The receiver cannot stall; a result must be captured the cycle it is shown.
//  - Synchronous reset clears the coefficients and flag to zero and drops every
//    request in flight.
`default_nettype none

module pressure_temperature_compensation_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [pt_comp_pkg::RAW_W-1:0]  req_pressure_raw,
   input  wire logic [pt_comp_pkg::RAW_W-1:0]  req_temperature_raw,
   output logic                               rsp_valid,
   output logic [pt_comp_pkg::PRESS_W-1:0]    rsp_pressure_dmbar,
   output logic [pt_comp_pkg::TEMPO_W-1:0]    rsp_temperature_centi,
   output logic [1:0]                         rsp_status,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pt_comp_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [pt_comp_pkg::COEF_W-1:0] csr_wdata
);

   pt_comp_pkg::cfg_type    cfg;
   logic                    first_valid;
   pt_comp_pkg::first_type  first_data;
   logic                    second_valid;
   pt_comp_pkg::second_type second_data;

   // Fully pipelined, never stalls
   assign busy = 1'b0;

   // Coefficient registers
   pt_comp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // First-order terms
   pt_comp_first u_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .d1        (req_pressure_raw),
      .d2        (req_temperature_raw),
      .cfg       (cfg),
      .out_valid (first_valid),
      .out_data  (first_data)
   );

   // Low-temperature correction
   pt_comp_second u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (first_valid),
      .in_data   (first_data),
      .out_valid (second_valid),
      .out_data  (second_data)
   );

   // Pressure and output register
   pt_comp_press u_press (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (second_valid),
      .in_data               (second_data),
      .rsp_valid             (rsp_valid),
      .rsp_pressure_dmbar    (rsp_pressure_dmbar),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_status            (rsp_status)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for pressure_temperature_compensation_top: directed table, then random
// readings under several coefficient sets, checked against fixed values or a built-in predictor.
// Depends on pt_comp_pkg and the compensation RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pt_comp_pkg::*;

   localparam int     CLK_PERIOD      = 10;
   localparam int     RESET_CYCLES    = 6;
   localparam int     LATENCY         = 11;
   localparam int     MAX_GAP         = 17;
   localparam int     STALL_LIMIT     = 1000;
   localparam int     RAND_PHASES     = 6;
   localparam int     ITEMS_PER_PHASE = 113;
   localparam longint RAW_MAX         = (64'sd1 <<< RAW_W) - 1;
   localparam longint DIV_2_7         = 64'sd1 <<< 7;
   localparam longint DIV_2_8         = 64'sd1 <<< 8;
   localparam longint DIV_2_15        = 64'sd1 <<< 15;
   localparam longint DIV_2_21        = 64'sd1 <<< 21;
   localparam longint DIV_2_23        = 64'sd1 <<< 23;
   localparam longint DIV_2_33        = 64'sd1 <<< 33;

   // index past the register list, writes must be dropped
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [PRESS_W-1:0] press;
      logic [TEMPO_W-1:0] temp;
      status_type         status;
   } reading_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_PREDICTED,
      ROW_FIXED
   } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [IDX_W-1:0]  index;
      logic [COEF_W-1:0] wdata;
      logic [RAW_W-1:0]  d1;
      logic [RAW_W-1:0]  d2;
      reading_type       expected;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [RAW_W-1:0]   req_pressure_raw = '0;
   logic [RAW_W-1:0]   req_temperature_raw = '0;
   logic               rsp_valid;
   logic [PRESS_W-1:0] rsp_pressure_dmbar;
   logic [TEMPO_W-1:0] rsp_temperature_centi;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index = '0;
   logic [COEF_W-1:0]  csr_wdata = '0;

   // typed expectation travels alongside the request it belongs to
   logic               fixed_pending = 1'b0;
   reading_type        fixed_value = '0;

   cfg_type            cal_shadow = '0;
   reading_type        pending_readings[$];
   stim_row_type       directed_rows[$];
   int unsigned        mismatch_count = 0;
   int unsigned        stall_cycles = 0;

   pressure_temperature_compensation_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_pressure_raw      (req_pressure_raw),
      .req_temperature_raw   (req_temperature_raw),
      .rsp_valid             (rsp_valid),
      .rsp_pressure_dmbar    (rsp_pressure_dmbar),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_status            (rsp_status),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Expected compensated reading for one raw pair under the current coefficients
   function automatic reading_type compensate(input logic [RAW_W-1:0] d1_raw,
                                              input logic [RAW_W-1:0] d2_raw);
      reading_type r;
      longint   d1, d2, k1, k2, k3, k4, k5, k6;
      longint   dt, temp, off, sens, t2, off2, sens2, dd, dl, p;
      r = '{press: '0, temp: '0, status: STATUS_OK};
      if (!cal_shadow.cal_valid) begin
         r.status = STATUS_NO_CAL;
         return r;
      end
      if (d1_raw == '0 || d2_raw == '0) begin
         r.status = STATUS_ZERO_RAW;
         return r;
      end
      d1 = d1_raw;
      d2 = d2_raw;
      k1 = cal_shadow.c1;
      k2 = cal_shadow.c2;
      k3 = cal_shadow.c3;
      k4 = cal_shadow.c4;
      k5 = cal_shadow.c5;
      k6 = cal_shadow.c6;

      // first order
      dt   = d2 - k5 * 256;
      temp = TEMP_REF + (dt * k6) / DIV_2_23;
      off  = k2 * 65536 + (k4 * dt) / DIV_2_7;
      sens = k1 * 32768 + (k3 * dt) / DIV_2_8;

      // low-temperature correction, extra term in the very cold range
      t2    = 0;
      off2  = 0;
      sens2 = 0;
      if (temp < TEMP_REF) begin
         dd    = temp - TEMP_REF;
         t2    = (3 * (dt * dt)) / DIV_2_33;
         off2  = (3 * dd * dd) / 2;
         sens2 = (5 * dd * dd) / 8;
         if (temp < TEMP_LOW) begin
            dl    = temp - TEMP_LOW;
            off2  = off2 + 7 * dl * dl;
            sens2 = sens2 + 4 * dl * dl;
         end
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;

      p = ((d1 * sens) / DIV_2_21 - off) / DIV_2_15;
      r.press = p[PRESS_W-1:0];
      r.temp  = temp[TEMPO_W-1:0];
      return r;
   endfunction

   function automatic stim_row_type row_write(input logic [IDX_W-1:0] index,
                                              input logic [COEF_W-1:0] value);
      stim_row_type r;
      r = '{kind: ROW_WRITE, index: index, wdata: value, d1: '0, d2: '0, expected: '0};
      return r;
   endfunction

   function automatic stim_row_type row_predicted(input logic [RAW_W-1:0] d1,
                                                  input logic [RAW_W-1:0] d2);
      stim_row_type r;
      r = '{kind: ROW_PREDICTED, index: '0, wdata: '0, d1: d1, d2: d2, expected: '0};
      return r;
   endfunction

   function automatic stim_row_type row_fixed(input logic [RAW_W-1:0] d1,
                                              input logic [RAW_W-1:0] d2,
                                              input logic [PRESS_W-1:0] press,
                                              input logic [TEMPO_W-1:0] temp,
                                              input status_type status);
      stim_row_type r;
      r = '{kind: ROW_FIXED, index: '0, wdata: '0, d1: d1, d2: d2,
            expected: '{press: press, temp: temp, status: status}};
      return r;
   endfunction

   // Present one request, hold it until taken, then idle for a random gap unless no_gaps is set
   task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                               input logic has_fixed, input reading_type fixed,
                               input bit no_gaps);
      int unsigned gap;
      csr_valid           <= 1'b0;
      req_pressure_raw    <= d1;
      req_temperature_raw <= d2;
      fixed_pending       <= has_fixed;
      fixed_value         <= fixed;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected result has come back
   task automatic wait_drain();
      start     <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   // Register write; csr_valid stays high for a following write until a request or drain drops it
   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [COEF_W-1:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Scoreboard: check results, track register writes, queue each request's expected reading
   always @(posedge clock) begin : scoreboard
      reading_type oldest;
      if (reset) begin
         cal_shadow = '0;
         pending_readings.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_readings.size() == 0) begin
               $error("unexpected result: pressure_dmbar %0d temperature_centi %0d status %0d",
                      $signed(rsp_pressure_dmbar), $signed(rsp_temperature_centi), rsp_status);
               mismatch_count++;
            end else begin
               oldest = pending_readings.pop_front();
               if (rsp_pressure_dmbar !== oldest.press) begin
                  $error("pressure_dmbar: expected %0d, actual %0d",
                         $signed(oldest.press), $signed(rsp_pressure_dmbar));
                  mismatch_count++;
               end
               if (rsp_temperature_centi !== oldest.temp) begin
                  $error("temperature_centi: expected %0d, actual %0d",
                         $signed(oldest.temp), $signed(rsp_temperature_centi));
                  mismatch_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_C1:        cal_shadow.c1 = csr_wdata;
               REG_C2:        cal_shadow.c2 = csr_wdata;
               REG_C3:        cal_shadow.c3 = csr_wdata;
               REG_C4:        cal_shadow.c4 = csr_wdata;
               REG_C5:        cal_shadow.c5 = csr_wdata;
               REG_C6:        cal_shadow.c6 = csr_wdata;
               REG_CAL_VALID: cal_shadow.cal_valid = csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (fixed_pending)
               pending_readings.push_back(fixed_value);
            else
               pending_readings.push_back(compensate(req_pressure_raw, req_temperature_raw));
         end
      end
   end

   // Watchdog on cycles with no request, result or register write
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [COEF_W-1:0] coef[6];
      logic              cal_ok;
      logic              writing;
      logic [RAW_W-1:0]  d1;
      logic [RAW_W-1:0]  d2;
      longint            center;
      longint            v;
      int unsigned       sel;
      int unsigned       spread;
      bit                no_gaps;

      // Directed table
      // calibration not loaded after reset
      directed_rows.push_back(row_fixed(24'h000000, 24'h000000, '0, '0, STATUS_NO_CAL));
      directed_rows.push_back(row_fixed(24'hFFFFFF, 24'hFFFFFF, '0, '0, STATUS_NO_CAL));
      directed_rows.push_back(row_fixed(24'h000001, 24'h000000, '0, '0, STATUS_NO_CAL));
      // all coefficients zero: reference temperature, zero pressure
      directed_rows.push_back(row_write(REG_CAL_VALID, 16'h0001));
      directed_rows.push_back(row_fixed(24'hFFFFFF, 24'hFFFFFF, '0, 19'd2000, STATUS_OK));
      directed_rows.push_back(row_fixed(24'h000000, 24'h000005, '0, '0, STATUS_ZERO_RAW));
      // typical coefficient set
      directed_rows.push_back(row_write(REG_C1, 16'd46372));
      directed_rows.push_back(row_write(REG_C2, 16'd43981));
      directed_rows.push_back(row_write(REG_C3, 16'd29059));
      directed_rows.push_back(row_write(REG_C4, 16'd27842));
      directed_rows.push_back(row_write(REG_C5, 16'd31553));
      directed_rows.push_back(row_write(REG_C6, 16'd28165));
      directed_rows.push_back(row_predicted(24'd4311550, 24'd8387300));
      directed_rows.push_back(row_fixed(24'd0, 24'd8387300, '0, '0, STATUS_ZERO_RAW));
      directed_rows.push_back(row_fixed(24'd4311550, 24'd0, '0, '0, STATUS_ZERO_RAW));
      directed_rows.push_back(row_predicted(24'h000001, 24'h000001));
      directed_rows.push_back(row_predicted(24'hFFFFFF, 24'hFFFFFF));
      directed_rows.push_back(row_predicted(24'hFFFFFF, 24'h000001));
      directed_rows.push_back(row_predicted(24'h000001, 24'hFFFFFF));
      // dT zero, then around the 20.00 C and -15.00 C thresholds
      directed_rows.push_back(row_predicted(24'd4311550, 24'd8077568));
      directed_rows.push_back(row_predicted(24'd4311550, 24'd8077270));
      directed_rows.push_back(row_predicted(24'd4311550, 24'd8077271));
      directed_rows.push_back(row_predicted(24'd4311550, 24'd7035161));
      directed_rows.push_back(row_predicted(24'd4311550, 24'd7034900));
      // every coefficient at its maximum
      directed_rows.push_back(row_write(REG_C1, 16'hFFFF));
      directed_rows.push_back(row_write(REG_C2, 16'hFFFF));
      directed_rows.push_back(row_write(REG_C3, 16'hFFFF));
      directed_rows.push_back(row_write(REG_C4, 16'hFFFF));
      directed_rows.push_back(row_write(REG_C5, 16'hFFFF));
      directed_rows.push_back(row_write(REG_C6, 16'hFFFF));
      directed_rows.push_back(row_predicted(24'hFFFFFF, 24'h000001));
      directed_rows.push_back(row_predicted(24'hFFFFFF, 24'hFFFFFF));
      directed_rows.push_back(row_predicted(24'h000001, 24'h000001));
      // write to an unused index changes nothing
      directed_rows.push_back(row_write(REG_UNUSED, 16'h1234));
      directed_rows.push_back(row_predicted(24'h800000, 24'h800000));
      // only bit 0 of the valid flag counts
      directed_rows.push_back(row_write(REG_CAL_VALID, 16'hFFFE));
      directed_rows.push_back(row_fixed(24'h800000, 24'h800000, '0, '0, STATUS_NO_CAL));
      directed_rows.push_back(row_write(REG_CAL_VALID, 16'h0001));
      directed_rows.push_back(row_predicted(24'h123456, 24'h654321));

      // Reset
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      writing = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (!writing) begin
               wait_drain();
               writing = 1'b1;
            end
            write_reg(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            writing = 1'b0;
            send_reading(directed_rows[i].d1, directed_rows[i].d2,
                         directed_rows[i].kind == ROW_FIXED, directed_rows[i].expected, 1'b0);
         end
      end

      // Random phases, each under its own coefficient set
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         foreach (coef[k]) begin
            case (phase)
               1:       coef[k] = 16'hFFFF;
               2:       coef[k] = 16'h0000;
               default: coef[k] = 16'($urandom_range(0, 16'hFFFF));
            endcase
         end
         cal_ok = (phase != 3);
         wait_drain();
         foreach (coef[k])
            write_reg(REG_C1 + IDX_W'(k), coef[k]);
         write_reg(REG_CAL_VALID, {15'($urandom), cal_ok});
         if ($urandom_range(0, 1) == 1)
            write_reg(REG_UNUSED, 16'($urandom));

         no_gaps = 1'b0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 25 == 0)
               no_gaps = ($urandom_range(0, 3) == 0);
            if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 79) == 0)
               wait_drain();

            // pressure: mostly full range, sometimes zero or maximum
            sel = $urandom_range(0, 15);
            if (sel == 0)
               d1 = '0;
            else if (sel == 1)
               d1 = '1;
            else
               d1 = RAW_W'($urandom_range(1, 24'hFFFFFF));

            // temperature: mostly clustered around the reference point
            sel = $urandom_range(0, 7);
            center = longint'(cal_shadow.c5) * 256;
            if (sel <= 1) begin
               d2 = RAW_W'($urandom);
            end else if (sel == 7) begin
               case ($urandom_range(0, 2))
                  0:       d2 = '0;
                  1:       d2 = 24'h000001;
                  default: d2 = '1;
               endcase
            end else begin
               spread = (sel == 6) ? (32'd1 << 23) : (32'd1 << 21);
               v = center - longint'(spread) + longint'($urandom_range(0, 2 * spread));
               if (v < 1)
                  v = 1;
               else if (v > RAW_MAX)
                  v = RAW_MAX;
               d2 = v[RAW_W-1:0];
            end
            send_reading(d1, d2, 1'b0, '0, no_gaps);
         end
      end

      // Drain and let any stray result show up
      wait_drain();
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_readings.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
